/* hdl/tt_pkg.sv */
package tt_pkg;

   localparam int TT_INDEX_BITS = 16;

   localparam int CSR_INDEX_W = 4;
   localparam int THRESH_W    = 15;

   localparam logic [CSR_INDEX_W-1:0] CSR_MATE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_WIN  = CSR_INDEX_W'(1);

   localparam logic [THRESH_W-1:0] MATE_RESET = THRESH_W'(9000);
   localparam logic [THRESH_W-1:0] WIN_RESET  = THRESH_W'(10000);

   localparam logic [2:0] KIND_PROBE = 3'd0;
   localparam logic [2:0] KIND_UPPER = 3'd1;
   localparam logic [2:0] KIND_LOWER = 3'd2;
   localparam logic [2:0] KIND_EXACT = 3'd3;
   localparam logic [2:0] KIND_SWEEP = 3'd4;

   localparam logic [1:0] BOUND_NONE  = 2'd0;
   localparam logic [1:0] BOUND_UPPER = 2'd1;
   localparam logic [1:0] BOUND_LOWER = 2'd2;
   localparam logic [1:0] BOUND_EXACT = 2'd3;

   localparam int FLAG_W   = 3;
   localparam int FLAG_CUR = 2;

   typedef struct packed {
      logic [2:0]         kind;
      logic [7:0]         search_depth;
      logic [7:0]         ply_from_root;
      logic signed [15:0] window_low;
      logic signed [15:0] window_high;
      logic signed [15:0] score_in;
      logic [15:0]        move_in;
      logic               side;
      logic [31:0]        position_key;
      logic [63:0]        position_lock;
   } item_type;

   typedef struct packed {
      logic [63:0]        lock;
      logic [7:0]         depth;
      logic [15:0]        move;
      logic signed [15:0] score;
      logic               score_ok;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic               hit;
      logic               score_valid;
      logic signed [15:0] score_out;
      logic [15:0]        move_out;
      logic               stored;
   } result_type;

   typedef struct packed {
      result_type         res;
      logic               data_we;
      logic               flags_we;
      logic [FLAG_W-1:0]  flags;
      entry_type          wdata;
   } eval_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP,
      ST_SWEEP_END
   } state_type;

endpackage

/* hdl/tt_ram.sv */
module tt_ram import tt_pkg::*; #(
   parameter int WIDTH  = FLAG_W,
   parameter int ADDR_W = TT_INDEX_BITS + 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [0:(2**ADDR_W)-1];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/tt_eval.sv */
module tt_eval import tt_pkg::*; (
   input  item_type            item,
   input  entry_type           entry,
   input  logic [FLAG_W-1:0]   flags,
   input  logic [THRESH_W-1:0] mate_threshold,
   input  logic [THRESH_W-1:0] win_threshold,
   output eval_type            ev
);

   logic signed [17:0] s;
   logic signed [17:0] mate;
   logic signed [17:0] win;
   logic signed [17:0] ply;
   logic signed [17:0] lo;
   logic signed [17:0] hi;
   logic signed [17:0] adj;
   logic               probe_ok;
   logic               hit;
   logic               skip;
   logic               st_ok;
   logic signed [17:0] st_s;
   logic [1:0]         bound;

   always_comb begin
      s     = 18'(entry.score);
      mate  = {3'b000, mate_threshold};
      win   = {3'b000, win_threshold};
      ply   = {10'd0, item.ply_from_root};
      lo    = 18'(item.window_low);
      hi    = 18'(item.window_high);
      bound = flags[1:0];
      hit   = (entry.lock == item.position_lock) && (bound != BOUND_NONE);

      // probe: mate scores pass with ply correction, others need depth and bound test
      adj      = s;
      probe_ok = 1'b0;
      if (s > mate) begin
         adj      = s - ply;
         probe_ok = 1'b1;
      end else if (s < -mate) begin
         adj      = s + ply;
         probe_ok = 1'b1;
      end else if (entry.depth >= item.search_depth) begin
         case (bound)
            BOUND_UPPER: probe_ok = (s <= lo);
            BOUND_LOWER: probe_ok = (s >= hi);
            default:     probe_ok = 1'b1;
         endcase
      end

      // store: depth-preferred replacement, range checks, mate distance from node
      skip  = flags[FLAG_CUR] && (entry.depth > item.search_depth);
      st_s  = 18'(item.score_in);
      st_ok = 1'b1;
      case (item.kind)
         KIND_UPPER: begin
            if (st_s > mate || st_s < -win) begin
               st_ok = 1'b0;
            end else if (st_s < -mate) begin
               st_s = st_s - ply;
            end
         end
         KIND_LOWER: begin
            if (st_s > win || st_s < -mate) begin
               st_ok = 1'b0;
            end else if (st_s > mate) begin
               st_s = st_s + ply;
            end
         end
         default: begin
            if (st_s > win || st_s < -win) begin
               st_ok = 1'b0;
            end else if (st_s > mate) begin
               st_s = st_s + ply;
            end else if (st_s < -mate) begin
               st_s = st_s - ply;
            end
         end
      endcase
      if (st_s > 18'sd32767 || st_s < -18'sd32768) begin
         st_ok = 1'b0;
      end

      ev                = '0;
      ev.wdata.lock     = item.position_lock;
      ev.wdata.depth    = item.search_depth;
      ev.wdata.move     = item.move_in;
      ev.wdata.score    = st_ok ? st_s[15:0] : 16'sd0;
      ev.wdata.score_ok = st_ok;

      case (item.kind)
         KIND_PROBE: begin
            ev.res.hit         = hit;
            ev.res.move_out    = hit ? entry.move : 16'd0;
            ev.res.score_valid = hit && entry.score_ok && probe_ok;
            ev.res.score_out   = ev.res.score_valid ? adj[15:0] : 16'sd0;
            ev.flags_we        = hit;
            ev.flags           = {1'b1, bound};
         end
         KIND_UPPER, KIND_LOWER, KIND_EXACT: begin
            ev.res.stored = !skip;
            ev.data_we    = !skip;
            ev.flags_we   = !skip;
            ev.flags      = {1'b1, item.kind[1:0]};
         end
         default: begin
            ev.res = '0;
         end
      endcase
   end

endmodule

/* hdl/transposition_table_unit.sv */
// channel  dir  handshake             payload
// req      in   req_tvalid/tready     tdata: depth, ply, window, score, move, key, lock
//                                     tuser: kind, side
// rsp      out  rsp_tvalid/tready     tdata: score_out, move_out
//                                     tuser: hit, score_valid, stored
// csr      in   csr_valid/csr_ready   csr_index, csr_data (threshold registers)
//
// Probe and store do one synchronous read of the entry and flag
// memories, then evaluate and write back. An age sweep walks the flag memory
// one entry a cycle through its read/write ports.
// After reset the flag memory is cleared, with req_tready low.
// A stalled result holds the next item at the input; csr writes are always taken.
module transposition_table_unit import tt_pkg::*; #(
   parameter int INDEX_BITS = TT_INDEX_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [7:0] search_depth, [15:8] ply_from_root, [31:16] window_low,
   // [47:32] window_high, [63:48] score_in, [79:64] move_in,
   // [111:80] position_key, [175:112] position_lock
   input  logic [175:0]           req_tdata,
   // [2:0] kind, [3] side
   input  logic [3:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [15:0] score_out, [31:16] move_out
   output logic [31:0]            rsp_tdata,
   // [0] hit, [1] score_valid, [2] stored
   output logic [2:0]             rsp_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [THRESH_W-1:0]    csr_data
);

   localparam int ADDR_W = INDEX_BITS + 1;

   state_type             state_ff, state_in;
   item_type              req_item;
   item_type              item_ff, item_in;
   logic [ADDR_W-1:0]     cnt_ff, cnt_in;
   logic                  sweep_wr_ff, sweep_wr_in;
   logic [ADDR_W-1:0]     sweep_addr_ff, sweep_addr_in;
   logic [THRESH_W-1:0]   mate_ff, mate_in;
   logic [THRESH_W-1:0]   win_ff, win_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_res_ff, rsp_res_in;

   logic                  req_accept;
   logic [ADDR_W-1:0]     req_addr;
   logic [ADDR_W-1:0]     item_addr;
   logic [ADDR_W-1:0]     flag_raddr;
   logic                  flag_we;
   logic [ADDR_W-1:0]     flag_waddr;
   logic [FLAG_W-1:0]     flag_wdata;
   logic [FLAG_W-1:0]     flag_rdata;
   logic                  data_we;
   entry_type             data_rdata;
   logic [ENTRY_W-1:0]    data_rbits;
   eval_type              ev;

   always_comb begin
      req_item.search_depth  = req_tdata[7:0];
      req_item.ply_from_root = req_tdata[15:8];
      req_item.window_low    = req_tdata[31:16];
      req_item.window_high   = req_tdata[47:32];
      req_item.score_in      = req_tdata[63:48];
      req_item.move_in       = req_tdata[79:64];
      req_item.position_key  = req_tdata[111:80];
      req_item.position_lock = req_tdata[175:112];
      req_item.kind          = req_tuser[2:0];
      req_item.side          = req_tuser[3];
   end

   assign req_addr   = {req_item.side, req_item.position_key[INDEX_BITS-1:0]};
   assign item_addr  = {item_ff.side, item_ff.position_key[INDEX_BITS-1:0]};
   assign req_accept = req_tvalid && req_tready;
   assign data_rdata = entry_type'(data_rbits);

   tt_ram #(.WIDTH(FLAG_W), .ADDR_W(ADDR_W)) u_flags (
      .clock (clock),
      .we    (flag_we),
      .waddr (flag_waddr),
      .wdata (flag_wdata),
      .raddr (flag_raddr),
      .rdata (flag_rdata)
   );

   tt_ram #(.WIDTH(ENTRY_W), .ADDR_W(ADDR_W)) u_entries (
      .clock (clock),
      .we    (data_we),
      .waddr (item_addr),
      .wdata (ev.wdata),
      .raddr (req_addr),
      .rdata (data_rbits)
   );

   tt_eval u_eval (
      .item           (item_ff),
      .entry          (data_rdata),
      .flags          (flag_rdata),
      .mate_threshold (mate_ff),
      .win_threshold  (win_ff),
      .ev             (ev)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (&cnt_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_item.kind == KIND_SWEEP) ? ST_SWEEP : ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         ST_SWEEP: begin
            if (&cnt_ff) begin
               state_in = ST_SWEEP_END;
            end
         end
         ST_SWEEP_END: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      req_tready    = 1'b0;
      item_in       = item_ff;
      cnt_in        = cnt_ff;
      sweep_wr_in   = 1'b0;
      sweep_addr_in = cnt_ff;
      flag_raddr    = req_addr;
      flag_we       = 1'b0;
      flag_waddr    = item_addr;
      flag_wdata    = ev.flags;
      data_we       = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_res_in    = rsp_res_ff;

      case (state_ff)
         ST_CLEAR: begin
            flag_we    = 1'b1;
            flag_waddr = cnt_ff;
            flag_wdata = '0;
            cnt_in     = cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            // result register must be free by the time the item completes
            req_tready = !rsp_valid_ff || rsp_tready;
            if (req_accept) begin
               item_in = req_item;
               cnt_in  = '0;
            end
         end
         ST_EXEC: begin
            flag_we      = ev.flags_we;
            data_we      = ev.data_we;
            rsp_valid_in = 1'b1;
            rsp_res_in   = ev.res;
         end
         ST_SWEEP: begin
            flag_raddr  = cnt_ff;
            sweep_wr_in = 1'b1;
            cnt_in      = cnt_ff + 1'b1;
         end
         ST_SWEEP_END: begin
            rsp_valid_in = 1'b1;
            rsp_res_in   = '0;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase

      // sweep write-back comes in the cycle after its read
      if (sweep_wr_ff) begin
         flag_we    = 1'b1;
         flag_waddr = sweep_addr_ff;
         flag_wdata = flag_rdata[FLAG_CUR] ? {1'b0, flag_rdata[1:0]} : '0;
      end
   end

   always_comb begin
      mate_in = mate_ff;
      win_in  = win_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MATE: mate_in = csr_data;
            CSR_WIN:  win_in  = csr_data;
            default:  mate_in = mate_ff;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         sweep_wr_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mate_ff      <= MATE_RESET;
         win_ff       <= WIN_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sweep_wr_ff  <= sweep_wr_in;
         rsp_valid_ff <= rsp_valid_in;
         mate_ff      <= mate_in;
         win_ff       <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      sweep_addr_ff <= sweep_addr_in;
      rsp_res_ff    <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_res_ff.move_out, rsp_res_ff.score_out};
   assign rsp_tuser  = {rsp_res_ff.stored, rsp_res_ff.score_valid, rsp_res_ff.hit};

`ifndef SYNTH
   a_exec_out_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> !rsp_valid_ff)
      else $error("result register busy when item completes");

   a_exec_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_item.kind != KIND_SWEEP) |=> (state_ff == ST_EXEC))
      else $error("probe or store did not enter execute");

   a_exec_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |=> rsp_valid_ff)
      else $error("no result after execute");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR || state_ff == ST_SWEEP) |-> !req_tready)
      else $error("input taken during memory pass");
`endif

endmodule
